// File: sv/sorted_record_table_binary_search_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted record table
// Clocked on aclk, quiet while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_RECORD_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_RECORD_TABLE_BINARY_SEARCH_ASSERT_SVH

// same-cycle implication
`define SRTBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRTBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/srtbs_pkg.sv
// ----------------------------------------------------------------------------
// srtbs_pkg
// Word types and codes shared by the sorted record table.
// ----------------------------------------------------------------------------
package srtbs_pkg;

    localparam logic       OP_APPEND = 1'b0;
    localparam logic       OP_SEARCH = 1'b1;

    localparam logic [1:0] STATUS_APPENDED  = 2'd0;
    localparam logic [1:0] STATUS_FOUND     = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  search_key;
        logic [9:0]  duration_minutes;
        logic [15:0] calories_burned;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  record_id;
        logic [9:0]  found_duration;
        logic [15:0] found_calories;
        logic [23:0] total_calories;
        logic [7:0]  record_count;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [9:0]  duration;
        logic [15:0] calories;
    } record_t;

endpackage

// File: sv/srtbs_store.sv
// ----------------------------------------------------------------------------
// srtbs_store
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srtbs_store
    import srtbs_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  record_t                  wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output record_t                  rd_data
);

    record_t mem [DEPTH];
    record_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/sorted_record_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_record_table_binary_search
// Record table with append and binary search by identifier.
// ----------------------------------------------------------------------------
// An append is accepted and written into the record memory; its result
// waits in ST_FINISH until the output register is free. A search on an empty
// table goes straight to ST_FINISH as well. Any other search probes the record
// memory once per cycle, taking up to floor(log2(TABLE_DEPTH))+1 probes (8 at
// a depth of 128), and then passes through ST_FINISH. The single read port of
// the memory, with its registered read data, sets the probe rate. One word is
// worked on at a time, and the next word can be taken in the cycle after the
// result is loaded. A new word is taken while the previous result still waits
// in the output register; the following result is held back until that one
// is taken. No clearing pass follows reset.
module sorted_record_table_binary_search
    import srtbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_PROBE  = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [23:0]     total_reg, total_next;
    logic [CW-1:0]   lo_reg, lo_next;
    logic [CW-1:0]   hi_reg, hi_next;
    logic [AW-1:0]   mid_reg, mid_next;
    logic [7:0]      key_reg, key_next;
    out_word_t       res_reg, res_next;
    out_word_t       out_reg, out_next;
    logic            m_valid_reg, m_valid_next;

    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    record_t         wr_data, rd_data;

    logic [CW-1:0]   cnt_inc;
    logic            full;
    logic [24:0]     sum;
    logic [23:0]     total_sat;
    logic [CW-1:0]   mid_ext;

    function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo,
                                             input logic [CW-1:0] hi);
        logic [CW-1:0] span;
        span = hi - lo - CW'(1);
        return AW'(lo + (span >> 1));
    endfunction

    srtbs_store #(
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cnt_inc   = count_reg + CW'(1);
    assign full      = (count_reg == CW'(TABLE_DEPTH));
    assign sum       = {1'b0, total_reg} + 25'(s_word.calories_burned);
    assign total_sat = sum[24] ? TOTAL_MAX : sum[23:0];
    assign mid_ext   = CW'(mid_reg);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        wr_en        = 1'b0;
        wr_addr      = AW'(count_reg);
        wr_data      = '{id: 8'(cnt_inc), duration: s_word.duration_minutes,
                         calories: s_word.calories_burned};
        rd_en        = 1'b0;
        rd_addr      = mid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_next = '0;
                    key_next = s_word.search_key;
                    if (s_word.opcode == OP_APPEND) begin
                        if (full) begin
                            res_next.status = STATUS_FULL;
                        end else begin
                            wr_en              = 1'b1;
                            count_next         = cnt_inc;
                            total_next         = total_sat;
                            res_next.status    = STATUS_APPENDED;
                            res_next.record_id = 8'(cnt_inc);
                        end
                        state_next = ST_FINISH;
                    end else begin
                        res_next.status = STATUS_NOT_FOUND;
                        lo_next         = '0;
                        hi_next         = count_reg;
                        if (count_reg != '0) begin
                            rd_en      = 1'b1;
                            rd_addr    = mid_of('0, count_reg);
                            mid_next   = rd_addr;
                            state_next = ST_PROBE;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_PROBE: begin
                if (rd_data.id == key_reg) begin
                    res_next.status         = STATUS_FOUND;
                    res_next.record_id      = rd_data.id;
                    res_next.found_duration = rd_data.duration;
                    res_next.found_calories = rd_data.calories;
                    state_next              = ST_FINISH;
                end else begin
                    if (key_reg < rd_data.id) begin
                        hi_next = mid_ext;
                    end else begin
                        lo_next = mid_ext + CW'(1);
                    end
                    if (lo_next < hi_next) begin
                        rd_en    = 1'b1;
                        rd_addr  = mid_of(lo_next, hi_next);
                        mid_next = rd_addr;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_next                = res_reg;
                    out_next.total_calories = total_reg;
                    out_next.record_count   = 8'(count_reg);
                    m_valid_next            = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        key_reg <= key_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule

// File: sv/srtbs_checker.sv
// ----------------------------------------------------------------------------
// srtbs_checker
// Port-level checks on the result words of the sorted record table.
// ----------------------------------------------------------------------------
`include "sorted_record_table_binary_search_assert.svh"

module srtbs_checker
    import srtbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_word,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_word
);

    logic s_unused;
    in_word_t s_word_unused;

    assign s_unused      = s_valid & s_ready;
    assign s_word_unused = s_word;

    `SRTBS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_word), "result word dropped or changed while stalled")

    `SRTBS_ASSERT_NOW(a_append_id, m_valid && m_word.status == STATUS_APPENDED, m_word.record_id == m_word.record_count && m_word.found_duration == 10'd0 && m_word.found_calories == 16'd0, "append word carries wrong identifier or record fields")

    `SRTBS_ASSERT_NOW(a_miss_zero, m_valid && (m_word.status == STATUS_NOT_FOUND || m_word.status == STATUS_FULL), m_word.record_id == 8'd0 && m_word.found_duration == 10'd0 && m_word.found_calories == 16'd0, "miss or full word carries record fields")

    `SRTBS_ASSERT_NOW(a_full_count, m_valid && m_word.status == STATUS_FULL, m_word.record_count == 8'(TABLE_DEPTH), "table full reported below depth")

endmodule

bind sorted_record_table_binary_search srtbs_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_checker (.*);
